FILE: sv/crsfr_pkg.sv
// ----------------------------------------------------------------------------
// crsfr_pkg
// Shared constants, CRC-8 step function and counter store request struct for
// the frame receiver.
// ----------------------------------------------------------------------------
package crsfr_pkg;

   localparam int unsigned TYPE_ENTRIES = 256;
   localparam int unsigned TYPE_AW      = $clog2(TYPE_ENTRIES);
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned CSR_IDX_W    = 2;

   localparam logic [BYTE_W-1:0] CRC_POLY   = 8'hD5;
   localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd2;

   localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'd200;
   localparam logic [BYTE_W-1:0] MAXLEN_RESET  = 8'd64;
   localparam logic [BYTE_W-1:0] CHTYPE_RESET  = 8'h16;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_VALUE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_TYPE = 2'd2;

   typedef struct packed {
      logic               rd_en;
      logic [TYPE_AW-1:0] rd_addr;
      logic               wr_en;
      logic [TYPE_AW-1:0] wr_addr;
      logic [BYTE_W-1:0]  wr_data;
   } cnt_req_type;

   // one byte of CRC-8, MSB first
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] v;
      v = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (v[BYTE_W-1]) begin
            v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[BYTE_W-2:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

FILE: sv/crsfr_count_store.sv
// ----------------------------------------------------------------------------
// crsfr_count_store
// Per-type frame counters: one synchronous RAM with registered read and a
// row of valid flags so that never-written entries read as zero.
// ----------------------------------------------------------------------------
module crsfr_count_store (
   input  logic                                clock,
   input  logic                                reset,
   input  crsfr_pkg::cnt_req_type              req,
   output logic [crsfr_pkg::BYTE_W-1:0]        rd_data
);

   logic [crsfr_pkg::BYTE_W-1:0] count_mem_ff [crsfr_pkg::TYPE_ENTRIES];
   logic [crsfr_pkg::TYPE_ENTRIES-1:0] valid_ff;
   logic [crsfr_pkg::BYTE_W-1:0] rd_raw_ff;
   logic                         rd_valid_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         count_mem_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_raw_ff <= count_mem_ff[req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

FILE: sv/crsf_frame_receiver_crc8.sv
// ----------------------------------------------------------------------------
// crsf_frame_receiver_crc8
// Flow: the edge taking the CRC byte issues the counter read (stage 1); the
// increment, write-back and result word register follow as stage 1 advances.
// Throughput: one byte per clock while req_ready is high; the counter RAM
// port sets the read-modify-write; frame ends are at least four bytes apart.
// Reset: sync hunting, registers to defaults, all 256 counters read as zero
// at once through cleared valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module crsf_frame_receiver_crc8 (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [crsfr_pkg::BYTE_W-1:0]          req_rx_byte,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [crsfr_pkg::BYTE_W-1:0]          rsp_frame_type,
   output logic [crsfr_pkg::BYTE_W-1:0]          rsp_frame_length,
   output logic                                  rsp_crc_ok,
   output logic [crsfr_pkg::BYTE_W-1:0]          rsp_type_count,
   output logic                                  rsp_counted,

   input  logic                                  csr_we,
   input  logic [crsfr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [crsfr_pkg::BYTE_W-1:0]          csr_wdata
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LEN,
      PH_TYPE,
      PH_BODY
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [crsfr_pkg::BYTE_W-1:0]  pos_ff, pos_in;
   logic [crsfr_pkg::BYTE_W-1:0]  len_ff, len_in;
   logic [crsfr_pkg::BYTE_W-1:0]  type_ff, type_in;
   logic [crsfr_pkg::BYTE_W-1:0]  crc_ff, crc_in;

   logic [crsfr_pkg::BYTE_W-1:0]  sync_ff, maxlen_ff, chtype_ff;

   logic                          s1_valid_ff;
   logic [crsfr_pkg::BYTE_W-1:0]  s1_type_ff, s1_len_ff;
   logic                          s1_ok_ff, s1_cnt_ff;

   logic                          rsp_valid_ff;
   logic [crsfr_pkg::BYTE_W-1:0]  rsp_type_ff, rsp_len_ff, rsp_count_ff;
   logic                          rsp_ok_ff, rsp_cnt_ff;

   logic                          accept;
   logic                          frame_end;
   logic                          s1_adv;
   logic                          ok_now;
   logic [crsfr_pkg::BYTE_W-1:0]  count_rd;
   logic [crsfr_pkg::BYTE_W-1:0]  count_new;
   crsfr_pkg::cnt_req_type        cnt_req;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;
   assign ok_now    = (crc_ff == req_rx_byte);

   // parser next state
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      type_in   = type_ff;
      crc_in    = crc_ff;
      frame_end = 1'b0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (req_rx_byte == sync_ff) begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            if (req_rx_byte < crsfr_pkg::MIN_LENGTH || req_rx_byte > maxlen_ff) begin
               phase_in = PH_HUNT;
            end else begin
               len_in   = req_rx_byte;
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            type_in  = req_rx_byte;
            crc_in   = crsfr_pkg::crc8_update('0, req_rx_byte);
            pos_in   = '0;
            phase_in = PH_BODY;
         end
         PH_BODY: begin
            if ({1'b0, pos_ff} + {1'b0, crsfr_pkg::MIN_LENGTH} != {1'b0, len_ff}) begin
               crc_in = crsfr_pkg::crc8_update(crc_ff, req_rx_byte);
               pos_in = pos_ff + 8'd1;
            end else begin
               frame_end = 1'b1;
               pos_in    = '0;
               phase_in  = PH_HUNT;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
         len_ff   <= '0;
         type_ff  <= '0;
         crc_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff   <= crsfr_pkg::SYNC_RESET;
         maxlen_ff <= crsfr_pkg::MAXLEN_RESET;
         chtype_ff <= crsfr_pkg::CHTYPE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            crsfr_pkg::CSR_SYNC_VALUE:   sync_ff   <= csr_wdata;
            crsfr_pkg::CSR_MAX_LENGTH:   maxlen_ff <= csr_wdata;
            crsfr_pkg::CSR_CHANNEL_TYPE: chtype_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: counter read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept && frame_end) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && frame_end) begin
         s1_type_ff <= type_ff;
         s1_len_ff  <= len_ff;
         s1_ok_ff   <= ok_now;
         s1_cnt_ff  <= ok_now && (type_ff != chtype_ff);
      end
   end

   assign count_new = count_rd + 8'd1;

   always_comb begin
      cnt_req.rd_en   = accept && frame_end;
      cnt_req.rd_addr = type_ff[crsfr_pkg::TYPE_AW-1:0];
      cnt_req.wr_en   = s1_adv && s1_cnt_ff;
      cnt_req.wr_addr = s1_type_ff[crsfr_pkg::TYPE_AW-1:0];
      cnt_req.wr_data = count_new;
   end

   crsfr_count_store u_count_store (
      .clock   (clock),
      .reset   (reset),
      .req     (cnt_req),
      .rd_data (count_rd)
   );

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_type_ff  <= s1_type_ff;
         rsp_len_ff   <= s1_len_ff;
         rsp_ok_ff    <= s1_ok_ff;
         rsp_cnt_ff   <= s1_cnt_ff;
         rsp_count_ff <= s1_cnt_ff ? count_new : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_type   = rsp_type_ff;
   assign rsp_frame_length = rsp_len_ff;
   assign rsp_crc_ok       = rsp_ok_ff;
   assign rsp_type_count   = rsp_count_ff;
   assign rsp_counted      = rsp_cnt_ff;

endmodule
